/* src/tcw_pkg.sv */
// shared types and constants for the text console writer
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int SCROLL_SRC = CELL_COUNT - COLUMNS;

   localparam int ADDR_W = 11;
   localparam int CNT_W  = $clog2(CELL_COUNT + 1);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int CELL_W = 16;
   localparam int CHAR_W = 8;
   localparam int MODE_W = 2;

   localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0F20;
   localparam logic [7:0]        RESET_COLOR = 8'h0F;
   localparam logic [7:0]        CH_NEWLINE  = 8'd10;
   localparam logic [7:0]        CH_BACKSPACE = 8'd8;
   localparam logic [7:0]        CH_SPACE    = 8'd32;

   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL
   } state_type;

endpackage

`default_nettype wire

/* src/tcw_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* src/text_console_writer.sv */
// text console writer top level: cursor control, scroll and clear sequencer
`timescale 1ns / 1ps
`default_nettype none

// Text console with an 80x25 screen of 16-bit cells (attribute byte high,
// character byte low) in one ram with a single write port and a registered
// read port. One request beat is taken at a time; each produces one response
// beat. A put character, newline, backspace or unused mode answers in the
// cycle after it is taken, a cell read once the registered ram read port
// has returned the cell. When a put moves the cursor off the last row, the
// sequencer walks the ram once, copying each cell from one row below and
// blanking the bottom row. A clear walks all 2000 cells with the blank
// cell. After reset the same clearing pass runs before the first request
// is taken; csr writes are taken at any time.
module text_console_writer
   import tcw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // char_code[7:0], cell_address[18:8], zero pad
   input  wire logic [1:0]  req_tuser,  // mode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // cursor_pos[10:0], read_cell[26:11], zero pad
   output logic      [0:0]  rsp_tuser,  // scrolled[0]
   input  wire logic        csr_wen,
   input  wire logic [7:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [7:0]        color_ff, color_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              clear_item_ff, clear_item_in;
   logic              addr_ok_ff, addr_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic              rsp_scr_ff, rsp_scr_in;

   logic [MODE_W-1:0] req_mode;
   logic [CHAR_W-1:0] req_char;
   logic [ADDR_W-1:0] req_addr;
   logic              accept;

   logic [ROW_W-1:0]  put_row;
   logic [COL_W-1:0]  put_col;
   logic              put_wr;
   logic [ROW_W-1:0]  put_wr_row;
   logic [COL_W-1:0]  put_wr_col;
   logic [CHAR_W-1:0] put_wr_char;
   logic              put_scroll;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;
   logic [CNT_W-1:0]  cnt_prev;
   logic [CNT_W-1:0]  cnt_src;

   function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] c);
      cell_index = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
   endfunction

   assign req_mode = req_tuser;
   assign req_char = req_tdata[7:0];
   assign req_addr = req_tdata[18:8];

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_cell_ff, cell_index(row_ff, col_ff)};
   assign rsp_tuser  = rsp_scr_ff;

   assign cnt_prev = cnt_ff - CNT_W'(1);
   assign cnt_src  = cnt_ff + CNT_W'(COLUMNS);

   tcw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELL_COUNT)
   ) u_screen (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // cursor update for a put beat
   always_comb begin
      put_row     = row_ff;
      put_col     = col_ff;
      put_wr      = 1'b0;
      put_wr_row  = row_ff;
      put_wr_col  = col_ff;
      put_wr_char = req_char;
      put_scroll  = 1'b0;
      if (req_char == CH_NEWLINE) begin
         put_col = '0;
         if (row_ff == ROW_W'(ROWS - 1)) begin
            put_scroll = 1'b1;
         end else begin
            put_row = row_ff + ROW_W'(1);
         end
      end else if (req_char == CH_BACKSPACE) begin
         put_wr_char = CH_SPACE;
         if (col_ff != '0) begin
            put_col    = col_ff - COL_W'(1);
            put_wr     = 1'b1;
            put_wr_col = col_ff - COL_W'(1);
         end else if (row_ff != '0) begin
            put_row    = row_ff - ROW_W'(1);
            put_col    = COL_W'(COLUMNS - 1);
            put_wr     = 1'b1;
            put_wr_row = row_ff - ROW_W'(1);
            put_wr_col = COL_W'(COLUMNS - 1);
         end
      end else begin
         put_wr = 1'b1;
         if (col_ff == COL_W'(COLUMNS - 1)) begin
            put_col = '0;
            if (row_ff == ROW_W'(ROWS - 1)) begin
               put_scroll = 1'b1;
            end else begin
               put_row = row_ff + ROW_W'(1);
            end
         end else begin
            put_col = col_ff + COL_W'(1);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_PUT:   state_in = put_scroll ? ST_SCROLL : ST_IDLE;
                  MODE_READ:  state_in = ST_READ;
                  MODE_CLEAR: state_in = ST_CLEAR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_SCROLL: begin
            if (cnt_ff == CNT_W'(CELL_COUNT)) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      color_in      = color_ff;
      cnt_in        = cnt_ff;
      clear_item_in = clear_item_ff;
      addr_ok_in    = addr_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_cell_in   = rsp_cell_ff;
      rsp_scr_in    = rsp_scr_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cell_index(put_wr_row, put_wr_col);
      ram_wr_data   = {color_ff, put_wr_char};
      ram_rd_addr   = req_addr;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_PUT: begin
                     ram_wr_en = put_wr;
                     row_in    = put_row;
                     col_in    = put_col;
                     cnt_in    = '0;
                     if (!put_scroll) begin
                        rsp_valid_in = 1'b1;
                        rsp_cell_in  = '0;
                        rsp_scr_in   = 1'b0;
                     end
                  end
                  MODE_READ: begin
                     addr_ok_in = req_addr < ADDR_W'(CELL_COUNT);
                  end
                  MODE_CLEAR: begin
                     cnt_in        = '0;
                     color_in      = RESET_COLOR;
                     row_in        = '0;
                     col_in        = '0;
                     clear_item_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_cell_in  = '0;
                     rsp_scr_in   = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_cell_in  = addr_ok_ff ? ram_rd_data : '0;
            rsp_scr_in   = 1'b0;
         end
         ST_SCROLL: begin
            // read one row ahead, write the cell behind the read pointer
            ram_rd_addr = (cnt_ff < CNT_W'(SCROLL_SRC)) ? cnt_src[ADDR_W-1:0]
                                                        : cnt_ff[ADDR_W-1:0];
            ram_wr_en   = cnt_ff != '0;
            ram_wr_addr = cnt_prev[ADDR_W-1:0];
            ram_wr_data = (cnt_prev < CNT_W'(SCROLL_SRC)) ? ram_rd_data : BLANK_CELL;
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELL_COUNT)) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = '0;
               rsp_scr_in   = 1'b1;
            end
         end
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff[ADDR_W-1:0];
            ram_wr_data = BLANK_CELL;
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               clear_item_in = 1'b0;
               if (clear_item_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_cell_in  = '0;
                  rsp_scr_in   = 1'b0;
               end
            end
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
      if (csr_wen) begin
         color_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         row_ff        <= '0;
         col_ff        <= '0;
         color_ff      <= RESET_COLOR;
         cnt_ff        <= '0;
         clear_item_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         color_ff      <= color_in;
         cnt_ff        <= cnt_in;
         clear_item_ff <= clear_item_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ok_ff  <= addr_ok_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

endmodule

`default_nettype wire

/* dv/testbench.sv */
// self-checking testbench for the text console writer: directed and random beats
`timescale 1ns / 1ps

import tcw_pkg::*;

localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

typedef struct packed {
   logic [ADDR_W-1:0] cursor_pos;
   logic [CELL_W-1:0] read_cell;
   logic              scrolled;
} screen_reply_type;

class console_scoreboard;
   logic [CELL_W-1:0] screen [CELL_COUNT];
   int unsigned       row;
   int unsigned       col;
   logic [7:0]        color;
   screen_reply_type  pending_replies [$];
   int unsigned       errors;

   function new();
      blank_screen();
      color  = RESET_COLOR;
      errors = 0;
   endfunction

   function void blank_screen();
      foreach (screen[i]) screen[i] = BLANK_CELL;
      row = 0;
      col = 0;
   endfunction

   function void write_cell(logic [CHAR_W-1:0] ch);
      screen[row * COLUMNS + col] = {color, ch};
   endfunction

   function void scroll_up();
      for (int i = 0; i < CELL_COUNT; i++) begin
         if (i + COLUMNS < CELL_COUNT)
            screen[i] = screen[i + COLUMNS];
         else
            screen[i] = BLANK_CELL;
      end
      row = ROWS - 1;
   endfunction

   // note an accepted request beat and queue the response it should produce
   function void note_request(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                              logic [ADDR_W-1:0] addr);
      screen_reply_type reply;
      reply = '0;
      case (mode)
         MODE_PUT: begin
            if (ch == CH_NEWLINE) begin
               col = 0;
               row++;
            end else if (ch == CH_BACKSPACE) begin
               if (col > 0) begin
                  col--;
                  write_cell(CH_SPACE);
               end else if (row > 0) begin
                  row--;
                  col = COLUMNS - 1;
                  write_cell(CH_SPACE);
               end
            end else begin
               write_cell(ch);
               col++;
               if (col >= COLUMNS) begin
                  col = 0;
                  row++;
               end
            end
            if (row >= ROWS) begin
               scroll_up();
               reply.scrolled = 1'b1;
            end
         end
         MODE_READ: begin
            if (addr < CELL_COUNT)
               reply.read_cell = screen[addr];
         end
         MODE_CLEAR: begin
            blank_screen();
            color = RESET_COLOR;
         end
         default: begin
         end
      endcase
      reply.cursor_pos = ADDR_W'(row * COLUMNS + col);
      pending_replies.push_back(reply);
   endfunction

   task report(string msg);
      errors++;
      if (errors <= 100)
         $display("mismatch: %s", msg);
   endtask

   task check_response(logic [ADDR_W-1:0] pos, logic [CELL_W-1:0] rd, logic scr);
      screen_reply_type want;
      if (pending_replies.size() == 0) begin
         report($sformatf("response beat with none expected, cursor_pos %0d", pos));
         return;
      end
      want = pending_replies.pop_front();
      if (pos !== want.cursor_pos)
         report($sformatf("cursor_pos %0d, expected %0d", pos, want.cursor_pos));
      if (rd !== want.read_cell)
         report($sformatf("read_cell %h, expected %h", rd, want.read_cell));
      if (scr !== want.scrolled)
         report($sformatf("scrolled %b, expected %b", scr, want.scrolled));
   endtask
endclass

module testbench;
   localparam int CYCLE_LIMIT     = 10_000_000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int SETTLE_CYCLES   = 2100;
   localparam logic [7:0] PHASE_COLORS [5] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h0F};

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [23:0]       req_tdata;  // char_code[7:0], cell_address[18:8], zero pad
   logic [1:0]        req_tuser;  // mode[1:0]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;  // cursor_pos[10:0], read_cell[26:11], zero pad
   logic [0:0]        rsp_tuser;  // scrolled[0]
   logic              csr_wen;
   logic [7:0]        csr_wdata;
   bit                sender_idles;
   bit                receiver_stalls;
   int unsigned       cycle_count;
   console_scoreboard sb = new();

   text_console_writer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_tuser, req_tdata[7:0], req_tdata[18:8]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata[10:0], rsp_tdata[26:11], rsp_tuser[0]);
   end

   // response side back-pressure
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = receiver_stalls ? $urandom_range(0, 12) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic write_color(logic [7:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      sb.color = value;
   endtask

   task automatic send_beat(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                            logic [ADDR_W-1:0] addr);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {5'b0, addr, ch};
      do @(posedge clock); while (!req_tready);
   endtask

   // step the clock first so the last accepted beat is already queued
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_beat();
      int unsigned       pick;
      logic [ADDR_W-1:0] addr;
      logic [CHAR_W-1:0] ch;
      pick = $urandom_range(0, 999);
      if (pick < 2) begin
         send_beat(MODE_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom));
      end else if (pick < 40) begin
         send_beat(MODE_SPARE, CHAR_W'($urandom), ADDR_W'($urandom));
      end else if (pick < 240) begin
         pick = $urandom_range(0, 9);
         if (pick < 5)
            addr = ADDR_W'(sb.row * COLUMNS + $urandom_range(0, COLUMNS - 1));
         else if (pick < 9)
            addr = ADDR_W'($urandom_range(0, CELL_COUNT - 1));
         else
            addr = ADDR_W'($urandom_range(CELL_COUNT, 2047));
         send_beat(MODE_READ, CHAR_W'($urandom), addr);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            ch = CH_NEWLINE;
         else if (pick < 14)
            ch = CH_BACKSPACE;
         else
            ch = CHAR_W'($urandom_range(0, 255));
         send_beat(MODE_PUT, ch, ADDR_W'($urandom));
      end
   endtask

   initial begin
      logic [7:0] phase_color;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = '0;
      csr_wen         = 1'b0;
      csr_wdata       = '0;
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // backspace at home, reset contents, field extremes
      send_beat(MODE_PUT, CH_BACKSPACE, 11'd0);
      send_beat(MODE_READ, 8'h00, 11'd0);
      send_beat(MODE_PUT, 8'h00, 11'd2047);
      send_beat(MODE_PUT, 8'hFF, 11'd0);
      send_beat(MODE_READ, 8'hFF, 11'd1);
      // newline, then backspace at column 0 and a write in the last column
      send_beat(MODE_PUT, CH_NEWLINE, 11'd0);
      send_beat(MODE_PUT, CH_BACKSPACE, 11'd0);
      send_beat(MODE_READ, 8'h00, 11'd79);
      send_beat(MODE_PUT, 8'h41, 11'd0);
      send_beat(MODE_READ, 8'h00, 11'd79);
      // backspace inside a row
      send_beat(MODE_PUT, 8'h42, 11'd0);
      send_beat(MODE_PUT, CH_BACKSPACE, 11'd0);
      send_beat(MODE_READ, 8'h00, 11'd80);
      // last cell and reads out of range
      send_beat(MODE_READ, 8'h00, 11'd1999);
      send_beat(MODE_READ, 8'h00, 11'd2000);
      send_beat(MODE_READ, 8'h00, 11'd2047);
      send_beat(MODE_SPARE, 8'hFF, 11'd2047);
      send_beat(MODE_CLEAR, 8'h00, 11'd0);
      send_beat(MODE_READ, 8'h00, 11'd0);
      send_beat(MODE_READ, 8'h00, 11'd81);
      drain_responses();

      for (int phase = 0; phase < PHASES; phase++) begin
         phase_color = (phase < 5) ? PHASE_COLORS[phase] : 8'($urandom);
         write_color(phase_color);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 40 == 0) begin
               sender_idles    = $urandom_range(0, 2) != 0;
               receiver_stalls = $urandom_range(0, 2) != 0;
            end
            send_random_beat();
         end
         drain_responses();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending_replies.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.pending_replies.size()));
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
